/* rtl/core/rbt_pkg.sv */
// Shared types and constants for the resource barrier tracker.
// Used by the interfaces, the update logic and the top level; depends on nothing.
package rbt_pkg;

  localparam int unsigned NumResources = 64;
  localparam int unsigned ResAddrW     = $clog2(NumResources);
  localparam int unsigned IndexW       = 6;
  localparam int unsigned LayoutW      = 31;
  localparam int unsigned MaskW        = 64;

  // request type codes
  localparam logic [1:0] ReqInit  = 2'd0;
  localparam logic [1:0] ReqUse   = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  localparam logic [LayoutW-1:0] LayoutUndefined = '0;

  // access bits that count as writes after reset
  localparam logic [MaskW-1:0] AccShaderWrite        = MaskW'(64'h1) << 6;
  localparam logic [MaskW-1:0] AccColorAttWrite      = MaskW'(64'h1) << 8;
  localparam logic [MaskW-1:0] AccDepthStencilWrite  = MaskW'(64'h1) << 10;
  localparam logic [MaskW-1:0] AccTransferWrite      = MaskW'(64'h1) << 12;
  localparam logic [MaskW-1:0] AccHostWrite          = MaskW'(64'h1) << 14;
  localparam logic [MaskW-1:0] AccMemoryWrite        = MaskW'(64'h1) << 16;
  localparam logic [MaskW-1:0] AccShaderStorageWrite = MaskW'(64'h1) << 34;
  localparam logic [MaskW-1:0] WriteMaskReset =
      AccShaderWrite | AccColorAttWrite | AccDepthStencilWrite | AccTransferWrite |
      AccHostWrite | AccMemoryWrite | AccShaderStorageWrite;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [IndexW-1:0]  resource_index;
    logic               is_write;
    logic               is_image;
    logic [LayoutW-1:0] layout;
    logic [MaskW-1:0]   stage;
    logic [MaskW-1:0]   access;
  } req_t;

  typedef struct packed {
    logic               barrier_valid;
    logic [IndexW-1:0]  resource_out;
    logic               image_flag;
    logic [LayoutW-1:0] old_layout;
    logic [LayoutW-1:0] new_layout;
    logic [MaskW-1:0]   src_stage;
    logic [MaskW-1:0]   src_access;
    logic [MaskW-1:0]   dst_stage;
    logic [MaskW-1:0]   dst_access;
  } rsp_t;

  // one hazard track entry
  typedef struct packed {
    logic [LayoutW-1:0] layout;
    logic [MaskW-1:0]   prod_stage;
    logic [MaskW-1:0]   prod_access;
    logic [MaskW-1:0]   flushed;
    logic [MaskW-1:0]   read_stages;
    logic [MaskW-1:0]   read_access;
  } entry_t;

  localparam entry_t EntryReset = '{layout: LayoutUndefined, default: '0};

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

/* rtl/core/rbt_req_if.sv */
// Request channel: valid/ready handshake carrying one rbt_pkg::req_t.
// Depends on rbt_pkg.
interface rbt_req_if;
  logic          valid;
  logic          ready;
  rbt_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/rbt_rsp_if.sv */
// Result channel: valid/ready handshake carrying one rbt_pkg::rsp_t.
// Depends on rbt_pkg.
interface rbt_rsp_if;
  logic          valid;
  logic          ready;
  rbt_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/rbt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rbt_step.sv */
// Barrier decision and track update for one request against its track entry.
// Pure combinational; depends on rbt_pkg.
module rbt_step (
  input  rbt_pkg::req_t                   req_i,
  input  rbt_pkg::entry_t                 entry_i,
  input  logic [rbt_pkg::MaskW-1:0]       wmask_i,
  output rbt_pkg::rsp_t                   rsp_o,
  output logic                            has_rsp_o,
  output logic                            wr_en_o,
  output rbt_pkg::entry_t                 entry_o
);

  logic                          idx_ok;
  logic                          layout_change;
  logic                          need_vis;
  logic [rbt_pkg::MaskW-1:0]     all_stage;
  logic [rbt_pkg::MaskW-1:0]     all_access;
  rbt_pkg::entry_t               fresh;

  assign idx_ok        = 32'(req_i.resource_index) < rbt_pkg::NumResources;
  assign layout_change = req_i.is_image && (entry_i.layout != req_i.layout);
  assign need_vis      = ((entry_i.prod_access & wmask_i) != '0) &&
                         ((req_i.stage & ~entry_i.flushed) != '0);
  assign all_stage     = entry_i.prod_stage | entry_i.read_stages;
  assign all_access    = entry_i.prod_access | entry_i.read_access;

  always_comb begin
    fresh             = '0;
    fresh.layout      = req_i.layout;
    fresh.prod_stage  = req_i.stage;
    fresh.prod_access = req_i.access;
  end

  always_comb begin
    rsp_o              = '0;
    rsp_o.resource_out = req_i.resource_index;
    rsp_o.image_flag   = req_i.is_image;
    has_rsp_o          = 1'b0;
    wr_en_o            = 1'b0;
    entry_o            = entry_i;
    unique case (req_i.req_type)
      rbt_pkg::ReqInit: begin
        wr_en_o = idx_ok;
        entry_o = fresh;
      end
      rbt_pkg::ReqQuery: begin
        has_rsp_o = 1'b1;
        if (idx_ok) begin
          rsp_o.barrier_valid = 1'b1;
          rsp_o.old_layout    = entry_i.layout;
          rsp_o.new_layout    = entry_i.layout;
          rsp_o.src_stage     = all_stage;
          rsp_o.src_access    = all_access;
        end
      end
      rbt_pkg::ReqUse: begin
        has_rsp_o = 1'b1;
        wr_en_o   = idx_ok;
        if (req_i.is_write) begin
          // write: wait on producer and all readers, then become the producer
          if (idx_ok && (layout_change || all_stage != '0)) begin
            rsp_o.barrier_valid = 1'b1;
            rsp_o.old_layout    = entry_i.layout;
            rsp_o.new_layout    = req_i.layout;
            rsp_o.src_stage     = all_stage;
            rsp_o.src_access    = all_access;
            rsp_o.dst_stage     = req_i.stage;
            rsp_o.dst_access    = req_i.access;
          end
          entry_o = fresh;
        end else begin
          // read: wait on producer only if its writes are not yet visible here
          if (idx_ok && (layout_change || need_vis)) begin
            rsp_o.barrier_valid = 1'b1;
            rsp_o.old_layout    = entry_i.layout;
            rsp_o.new_layout    = req_i.layout;
            rsp_o.src_stage     = entry_i.prod_stage;
            rsp_o.src_access    = entry_i.prod_access;
            rsp_o.dst_stage     = req_i.stage;
            rsp_o.dst_access    = req_i.access;
            entry_o.layout      = req_i.layout;
            entry_o.flushed     = entry_i.flushed | req_i.stage;
          end
          entry_o.read_stages = entry_i.read_stages | req_i.stage;
          entry_o.read_access = entry_i.read_access | req_i.access;
        end
      end
      default: begin
        has_rsp_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/resource_barrier_tracker.sv */
// Resource barrier tracker: per-resource hazard tracks and barrier decisions.
// A request is registered in stage 1 and its result in the output register.
// Throughput: one request per cycle unless the output stalls, set by the single
// RAM read-modify-write (read on transfer, write on advance, one-entry bypass).
// Reset: async active low; clears control state, the per-entry valid bits and
// loads the write access mask; track RAM contents need no clearing.
module resource_barrier_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rbt_pkg::MaskW-1:0] cfg_wdata_i,
  rbt_req_if.sink                   req_i,
  rbt_rsp_if.source                 rsp_o
);

  localparam int unsigned AddrW = rbt_pkg::ResAddrW;

  // write access mask register
  logic [rbt_pkg::MaskW-1:0] wmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmask_q <= rbt_pkg::WriteMaskReset;
    end else if (cfg_we_i) begin
      wmask_q <= cfg_wdata_i;
    end
  end

  // stage 1: request register plus the track entry read for it
  logic                   s1_valid_q;
  rbt_pkg::req_t          s1_req_q;
  logic                   s1_rd_valid_q;   // entry was written since reset
  logic                   fwd_q;           // previous request wrote this entry
  rbt_pkg::entry_t        fwd_entry_q;
  logic [rbt_pkg::EntryW-1:0] ram_rdata;
  rbt_pkg::entry_t        cur_entry;

  // per-entry valid bits; an entry not yet written reads as the reset entry
  logic [rbt_pkg::NumResources-1:0] vbits_q;

  // update logic outputs
  rbt_pkg::rsp_t          step_rsp;
  logic                   step_has_rsp;
  logic                   step_wr_en;
  rbt_pkg::entry_t        step_entry;

  // output register
  logic                   out_valid_q;
  rbt_pkg::rsp_t          out_q;

  logic                   s1_adv;
  logic                   in_xfer;
  logic                   ram_we;
  logic [AddrW-1:0]       in_addr;
  logic [AddrW-1:0]       s1_addr;

  assign in_addr = AddrW'(req_i.payload.resource_index);
  assign s1_addr = AddrW'(s1_req_q.resource_index);

  // advance stage 1 when its result (if any) has a free output slot
  assign s1_adv  = s1_valid_q && (!step_has_rsp || !out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer = req_i.valid && req_i.ready;
  assign ram_we  = s1_adv && step_wr_en;

  rbt_ram #(
    .Width (rbt_pkg::EntryW),
    .Depth (rbt_pkg::NumResources)
  ) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (step_entry),
    .re_i    (in_xfer),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // bypass the write of the previous request, which lands at the same edge
  // that reads for this one
  always_comb begin
    if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else if (s1_rd_valid_q) begin
      cur_entry = rbt_pkg::entry_t'(ram_rdata);
    end else begin
      cur_entry = rbt_pkg::EntryReset;
    end
  end

  rbt_step u_step (
    .req_i     (s1_req_q),
    .entry_i   (cur_entry),
    .wmask_i   (wmask_q),
    .rsp_o     (step_rsp),
    .has_rsp_o (step_has_rsp),
    .wr_en_o   (step_wr_en),
    .entry_o   (step_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s1_rd_valid_q <= 1'b0;
      fwd_q         <= 1'b0;
      vbits_q       <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q    <= 1'b1;
        s1_rd_valid_q <= vbits_q[in_addr];
        fwd_q         <= ram_we && (s1_addr == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (ram_we) begin
        vbits_q[s1_addr] <= 1'b1;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q    <= req_i.payload;
      fwd_entry_q <= step_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && step_has_rsp) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && step_has_rsp) begin
      out_q <= step_rsp;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // a track write marks its entry valid
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> vbits_q[$past(s1_addr)])
    else $error("track write did not set entry valid bit");

  // a bypass is only armed when a RAM write coincided with the read
  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !ram_we) |=> !fwd_q)
    else $error("bypass armed without a track write");

  // a held result is never overwritten by stage 1
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !(s1_adv && step_has_rsp))
    else $error("stage 1 advanced into a stalled output register");

endmodule
